/* src/hotp_pkg.sv */
package hotp_pkg;

   // Digest bytes kept: offsets 0..15 plus three
   localparam int STORE_DEPTH = 19;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // Digit emission
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int NDIG_W      = 4;
   localparam logic [NDIG_W-1:0] DIGIT_COUNT_RESET = 4'd6;

   // Word width after the top bit is masked off
   localparam int WORD_W = 31;
   // Reciprocal of ten: q = (w * RECIP_TEN) >> RECIP_SHIFT is exact for 32-bit w
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          PROD_W      = WORD_W + 32;

   typedef struct packed {
      logic [7:0] hmac_byte;
      logic       is_last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] code_digit;
      logic       is_last_digit;
      logic       short_message;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

endpackage

/* src/hotp_truncate_to_digits.sv */
// Channel  Direction  Payload                                     Handshake
// req      in         hmac_byte, is_last_byte                     req_valid / req_ready
// rsp      out        code_digit, is_last_digit, short_message    rsp_valid / rsp_ready
// csr      in         digit_count (4 bits)                        csr_valid / csr_ready
//
// A byte that is not last is taken without leaving the idle state; bytes may follow back to back.
// A last byte fetches the four chosen bytes through the single read port of the digest
// store, then takes each digit through a multiply and a divide state on the shared
// divide-by-ten multiplier; the digits then go one by one into the output register.
// Reset is synchronous; digit_count returns to 6 and the byte count to zero.
// The next message is taken while the final digit still waits in the output register.
module hotp_truncate_to_digits (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  hotp_pkg::req_type         req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output hotp_pkg::rsp_type         rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [3:0]                csr_digit_count
);

   // Digest store, read data registered in the cycle after the address
   logic [7:0] store_mem [hotp_pkg::STORE_DEPTH];
   logic [7:0] rd_data_ff;

   hotp_pkg::state_type state_ff, state_in;

   logic [hotp_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [hotp_pkg::COUNT_W-1:0]     idx_ff, idx_in;
   logic [3:0]                       offset_ff, offset_in;
   logic [hotp_pkg::NDIG_W-1:0]      ndig_ff, ndig_in;
   logic [hotp_pkg::NDIG_W-1:0]      digit_count_ff, digit_count_in;
   logic [2:0]                       rd_cnt_ff, rd_cnt_in;
   logic                             prev_ok_ff, prev_ok_in;
   logic                             short_ff, short_in;
   logic [31:0]                      word_ff, word_in;
   logic [hotp_pkg::WORD_W-1:0]      work_ff, work_in;
   logic [hotp_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [3:0]                       dig_ff [hotp_pkg::MAX_DIGITS];
   logic [hotp_pkg::DIGIT_IDX_W-1:0] dcnt_ff, dcnt_in;
   logic [hotp_pkg::DIGIT_IDX_W-1:0] ecnt_ff, ecnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   hotp_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                             req_fire;
   logic                             wr_en;
   logic [hotp_pkg::ADDR_W-1:0]      rd_addr;
   logic                             rd_ok;
   logic [hotp_pkg::WORD_W-1:0]      quot;
   logic [hotp_pkg::WORD_W-1:0]      quot_x10;
   logic [hotp_pkg::WORD_W-1:0]      rem_full;
   logic                             dig_wr;
   logic                             out_free;

   assign req_ready   = (state_ff == hotp_pkg::ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Store a byte while its index is inside the store
   assign wr_en = req_fire &&
                  (count_ff < hotp_pkg::COUNT_W'(hotp_pkg::STORE_DEPTH));

   // Chosen byte position and whether the message reached it
   assign rd_addr = hotp_pkg::ADDR_W'(offset_ff) + hotp_pkg::ADDR_W'(rd_cnt_ff[1:0]);
   assign rd_ok   = hotp_pkg::COUNT_W'(rd_addr) <= idx_ff;

   // Quotient and remainder of the working value by ten
   assign quot     = hotp_pkg::WORD_W'(prod_ff[hotp_pkg::PROD_W-1:hotp_pkg::RECIP_SHIFT]);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem_full = work_ff - quot_x10;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[hotp_pkg::ADDR_W-1:0]] <= req_payload.hmac_byte;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Next state, counters and datapath
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      offset_in      = offset_ff;
      ndig_in        = ndig_ff;
      digit_count_in = digit_count_ff;
      rd_cnt_in      = rd_cnt_ff;
      prev_ok_in     = prev_ok_ff;
      short_in       = short_ff;
      word_in        = word_ff;
      work_in        = work_ff;
      prod_in        = prod_ff;
      dcnt_in        = dcnt_ff;
      ecnt_in        = ecnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      dig_wr         = 1'b0;

      // Drop the output transaction once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         digit_count_in = csr_digit_count;
      end

      case (state_ff)
         hotp_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.is_last_byte) begin
                  count_in  = '0;
                  idx_in    = count_ff;
                  offset_in = req_payload.hmac_byte[3:0];
                  if (digit_count_ff == '0) begin
                     ndig_in = hotp_pkg::NDIG_W'(1);
                  end else if (digit_count_ff > hotp_pkg::NDIG_W'(hotp_pkg::MAX_DIGITS)) begin
                     ndig_in = hotp_pkg::NDIG_W'(hotp_pkg::MAX_DIGITS);
                  end else begin
                     ndig_in = digit_count_ff;
                  end
                  rd_cnt_in = '0;
                  short_in  = 1'b0;
                  word_in   = '0;
                  state_in  = hotp_pkg::ST_READ;
               end else if (count_ff != hotp_pkg::COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end

         hotp_pkg::ST_READ: begin
            // Shift in the byte read last cycle, zero when missing
            if (rd_cnt_ff != '0) begin
               word_in  = {word_ff[23:0], (prev_ok_ff ? rd_data_ff : 8'h00)};
               short_in = short_ff || !prev_ok_ff;
            end
            prev_ok_in = rd_ok;
            if (rd_cnt_ff == 3'd4) begin
               work_in  = word_in[hotp_pkg::WORD_W-1:0];
               dcnt_in  = '0;
               state_in = hotp_pkg::ST_MUL;
            end else begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
         end

         hotp_pkg::ST_MUL: begin
            prod_in  = hotp_pkg::PROD_W'(work_ff) * hotp_pkg::PROD_W'(hotp_pkg::RECIP_TEN);
            state_in = hotp_pkg::ST_DIV;
         end

         hotp_pkg::ST_DIV: begin
            // Peel off the least significant digit
            dig_wr  = 1'b1;
            work_in = quot;
            if (hotp_pkg::NDIG_W'(dcnt_ff) == ndig_ff - 1'b1) begin
               ecnt_in  = dcnt_ff;
               state_in = hotp_pkg::ST_EMIT;
            end else begin
               dcnt_in  = dcnt_ff + 1'b1;
               state_in = hotp_pkg::ST_MUL;
            end
         end

         hotp_pkg::ST_EMIT: begin
            // Hand out digits most significant first
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.code_digit    = dig_ff[ecnt_ff];
               rsp_data_in.is_last_digit = (ecnt_ff == '0);
               rsp_data_in.short_message = short_ff;
               if (ecnt_ff == '0) begin
                  state_in = hotp_pkg::ST_IDLE;
               end else begin
                  ecnt_in = ecnt_ff - 1'b1;
               end
            end
         end

         default: begin
            state_in = hotp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= hotp_pkg::ST_IDLE;
         count_ff       <= '0;
         digit_count_ff <= hotp_pkg::DIGIT_COUNT_RESET;
         rd_cnt_ff      <= '0;
         dcnt_ff        <= '0;
         ecnt_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         digit_count_ff <= digit_count_in;
         rd_cnt_ff      <= rd_cnt_in;
         dcnt_ff        <= dcnt_in;
         ecnt_ff        <= ecnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      offset_ff   <= offset_in;
      ndig_ff     <= ndig_in;
      prev_ok_ff  <= prev_ok_in;
      short_ff    <= short_in;
      word_ff     <= word_in;
      work_ff     <= work_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      if (dig_wr) begin
         dig_ff[dcnt_ff] <= rem_full[3:0];
      end
   end

   // A finished message leaves the byte count at zero
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.is_last_byte) |=> (count_ff == '0))
      else $error("byte count not cleared after last byte");

   // The remainder of a divide by ten is a decimal digit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hotp_pkg::ST_DIV) |-> (rem_full < hotp_pkg::WORD_W'(10)))
      else $error("divide by ten remainder out of range");

   // Reads stay inside the digest store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hotp_pkg::ST_READ) |->
         (rd_addr < hotp_pkg::ADDR_W'(hotp_pkg::STORE_DEPTH)))
      else $error("digest store read out of range");

   // Emission never starts past the chosen digit count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hotp_pkg::ST_EMIT) |-> (hotp_pkg::NDIG_W'(ecnt_ff) < ndig_ff))
      else $error("digit index beyond digit count");

endmodule

/* sim/hotp_digit_checker.sv */
`timescale 1ns / 100ps

module hotp_digit_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  hotp_pkg::req_type   req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  hotp_pkg::rsp_type   rsp_payload,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [3:0]          csr_digit_count,
   output int                  mismatches,
   output int                  digits_pending,
   output int                  digits_checked
);

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the block's message state and setting
   logic [7:0]                     digest_copy [hotp_pkg::STORE_DEPTH];
   logic [hotp_pkg::COUNT_W-1:0]   bytes_seen;
   logic [hotp_pkg::NDIG_W-1:0]    digits_setting;
   hotp_pkg::rsp_type              expected_digits [$];
   int                             error_total;
   int                             checked_total;

   // Clamp the programmed digit count to the range the block supports
   function automatic int digits_in_use(logic [hotp_pkg::NDIG_W-1:0] setting);
      if (setting == 0)
         return 1;
      if (setting > hotp_pkg::MAX_DIGITS)
         return hotp_pkg::MAX_DIGITS;
      return int'(setting);
   endfunction

   function automatic void clear_message();
      foreach (digest_copy[i])
         digest_copy[i] = 8'h00;
      bytes_seen = '0;
   endfunction

   // Store one digest byte; on the last one truncate and queue the code digits
   task automatic absorb_digest_byte(hotp_pkg::req_type item);
      int                 idx;
      int                 msg_len;
      int                 offset;
      int                 pos;
      int                 n;
      int                 k;
      logic [31:0]        word;
      logic               short_flag;
      logic [3:0]         digit_list [hotp_pkg::MAX_DIGITS];
      hotp_pkg::rsp_type  code_item;

      idx = int'(bytes_seen);
      if (idx < hotp_pkg::STORE_DEPTH)
         digest_copy[idx] = item.hmac_byte;
      if (bytes_seen < hotp_pkg::COUNT_MAX)
         bytes_seen = bytes_seen + 1'b1;
      if (!item.is_last_byte)
         return;

      // Assemble the big-endian word; bytes past the message read as zero
      msg_len    = idx + 1;
      offset     = int'(item.hmac_byte[3:0]);
      word       = '0;
      short_flag = 1'b0;
      for (k = 0; k < 4; k++) begin
         pos = offset + k;
         if (pos < msg_len && pos < hotp_pkg::STORE_DEPTH) begin
            word = {word[23:0], digest_copy[pos]};
         end else begin
            word       = {word[23:0], 8'h00};
            short_flag = 1'b1;
         end
      end
      word[31] = 1'b0;

      // Split into decimal digits, least significant first
      n = digits_in_use(digits_setting);
      for (k = 0; k < n; k++) begin
         digit_list[k] = 4'(word % 10);
         word          = word / 10;
      end

      // Queue most significant first, marking the final digit
      for (k = n - 1; k >= 0; k--) begin
         code_item.code_digit    = digit_list[k];
         code_item.is_last_digit = (k == 0);
         code_item.short_message = short_flag;
         expected_digits.push_back(code_item);
      end

      clear_message();
   endtask

   // Compare one delivered digit against the oldest expectation
   task automatic check_digit(hotp_pkg::rsp_type got);
      hotp_pkg::rsp_type want;

      checked_total++;
      if (expected_digits.size() == 0) begin
         if (error_total < REPORT_LIMIT)
            $display("%0t: unexpected digit %0d last %0b short %0b", $realtime,
                     got.code_digit, got.is_last_digit, got.short_message);
         error_total++;
         return;
      end
      want = expected_digits.pop_front();
      if (got.code_digit !== want.code_digit || got.is_last_digit !== want.is_last_digit
          || got.short_message !== want.short_message) begin
         if (error_total < REPORT_LIMIT)
            $display("%0t: digit mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b", $realtime,
                     want.code_digit, want.is_last_digit, want.short_message,
                     got.code_digit, got.is_last_digit, got.short_message);
         error_total++;
      end
   endtask

   // Watch all three channels; check results before absorbing new input
   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         digits_setting = hotp_pkg::DIGIT_COUNT_RESET;
         expected_digits.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_digit(rsp_payload);
         if (csr_valid && csr_ready)
            digits_setting = csr_digit_count;
         if (req_valid && req_ready)
            absorb_digest_byte(req_payload);
      end
      mismatches     <= error_total;
      digits_pending <= expected_digits.size();
      digits_checked <= checked_total;
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int PHASE_ITEMS    = 6;
   localparam int NUM_PHASES     = 8;
   localparam int LONG_DIGEST    = 130;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   hotp_pkg::req_type             req_payload     = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   hotp_pkg::rsp_type             rsp_payload;
   logic                          csr_valid       = 1'b0;
   logic                          csr_ready;
   logic [hotp_pkg::NDIG_W-1:0]   csr_digit_count = hotp_pkg::DIGIT_COUNT_RESET;

   int                            send_idle_pct   = 0;
   int                            stall_pct       = 0;
   logic                          holdoff_arm     = 1'b0;
   int                            items_sent      = 0;
   int                            messages_sent   = 0;
   int                            mismatches;
   int                            digits_pending;
   int                            digits_checked;

   always #1 clock = ~clock;

   hotp_truncate_to_digits uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_digit_count (csr_digit_count)
   );

   hotp_digit_checker digit_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_digit_count (csr_digit_count),
      .mismatches      (mismatches),
      .digits_pending  (digits_pending),
      .digits_checked  (digits_checked)
   );

   // Abort a hung run
   initial begin : watchdog
      #400000;
      $display("timeout: block stopped making progress");
      $display("*** FAILED ***");
      $finish;
   end

   // Drive rsp_ready: random stalls, plus one long hold-off when armed
   initial begin : receiver
      bit holdoff_taken;
      holdoff_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_arm && !holdoff_taken) begin
            holdoff_taken = 1'b1;
            repeat (HOLDOFF_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 77;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 77;
         end
         default: begin
            send_idle_pct = 37;
            stall_pct     = 37;
         end
      endcase
   endfunction

   // Offer one digest byte and hold it until accepted
   task automatic send_byte(logic [7:0] value, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {value, last};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drop valid, wait for every queued digit, then let the block go quiet
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (digits_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_digit_count(logic [hotp_pkg::NDIG_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_digit_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Send a digest of the given length; the last byte picks a random offset
   task automatic send_message(int len, bit all_ones);
      int i;
      for (i = 0; i < len - 1; i++)
         send_byte(all_ones ? 8'hFF : 8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b1);
      messages_sent++;
   endtask

   // Mostly short digests so offsets often run past the end
   task automatic random_message();
      int sel;
      int len;
      sel = $urandom_range(99);
      if (sel < 55)
         len = $urandom_range(1, 6);
      else if (sel < 85)
         len = $urandom_range(7, 19);
      else if (sel < 97)
         len = $urandom_range(20, 24);
      else
         len = 32;
      send_message(len, $urandom_range(4) == 0);
      if ($urandom_range(9) == 0)
         wait_drain();
   endtask

   // Edge cases: lone last byte, full word with top bit set, highest offset
   task automatic directed_digests();
      int i;
      send_byte(8'h00, 1'b1);
      send_byte(8'hAB, 1'b0);
      send_byte(8'h01, 1'b1);
      repeat (3) send_byte(8'hFF, 1'b0);
      send_byte(8'hF0, 1'b1);
      for (i = 0; i < hotp_pkg::STORE_DEPTH - 1; i++)
         send_byte((i >= 15) ? 8'hFF : 8'(i), 1'b0);
      send_byte(8'hFF, 1'b1);
      messages_sent += 4;
   endtask

   initial begin : stimulus
      logic [hotp_pkg::NDIG_W-1:0] phase_digits [NUM_PHASES];
      idle_mode_type               phase_idle [NUM_PHASES];
      int                          p;
      int                          phase_start;

      phase_digits = '{4'd6, 4'd10, 4'd1, 4'd0, 4'd15, 4'd3, 4'd11, 4'd7};
      phase_idle   = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                       IDLE_NONE, IDLE_SENDER, IDLE_BOTH, IDLE_RECEIVER};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < NUM_PHASES; p++) begin
         // Reprogram only once the block is quiet
         if (p > 0) begin
            wait_drain();
            write_digit_count((p == NUM_PHASES - 1) ? 4'($urandom_range(15)) : phase_digits[p]);
         end
         set_idling(phase_idle[p]);
         phase_start = items_sent;

         if (p == 0)
            directed_digests();
         if (p == 2)
            send_message(LONG_DIGEST, 1'b0);
         // Hold the receiver off while short digests keep coming
         if (p == 4) begin
            holdoff_arm <= 1'b1;
            repeat (6) send_message($urandom_range(1, 3), 1'b0);
         end

         while (items_sent - phase_start < PHASE_ITEMS)
            random_message();
      end

      wait_drain();
      $display("Sent %0d digest bytes in %0d messages; checked %0d code digits.",
               items_sent, messages_sent, digits_checked);
      $display("Digit counts in and out of range, short and long digests, stalls and a hold-off.");
      if (mismatches == 0 && digits_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
